/* hw/rtl/wpp_pkg.sv */
// Shared types and constants for the WAV PCM stream parser.
// No dependencies; used by wpp_rate_check and wav_pcm_stream_parser.
`default_nettype none

package wpp_pkg;

  // header byte positions of the checks (last byte of each field)
  localparam logic [5:0] POS_RIFF      = 6'd3;
  localparam logic [5:0] POS_RIFF_SIZE = 6'd7;
  localparam logic [5:0] POS_WAVE      = 6'd11;
  localparam logic [5:0] POS_FMT       = 6'd15;
  localparam logic [5:0] POS_FMT_LEN   = 6'd19;
  localparam logic [5:0] POS_FMT_TYPE  = 6'd21;
  localparam logic [5:0] POS_CHANNELS  = 6'd23;
  localparam logic [5:0] POS_RATE      = 6'd27;
  localparam logic [5:0] POS_BYTE_RATE = 6'd31;
  localparam logic [5:0] POS_BITS      = 6'd35;
  localparam logic [5:0] POS_DATA      = 6'd39;
  localparam logic [5:0] POS_LAST      = 6'd43;

  // two-byte fields live in [20,24) and [32,36)
  localparam logic [5:0] SHORT_A_LO = 6'd20;
  localparam logic [5:0] SHORT_A_HI = 6'd24;
  localparam logic [5:0] SHORT_B_LO = 6'd32;
  localparam logic [5:0] SHORT_B_HI = 6'd36;

  localparam logic [31:0] TAG_RIFF    = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE    = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT     = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA    = 32'h6174_6164;
  localparam logic [31:0] FMT_LEN     = 32'd16;
  localparam logic [31:0] FMT_PCM     = 32'd1;
  localparam logic [32:0] SIZE_OFFSET = 33'd36;

  localparam logic [1:0] CH_MONO   = 2'd1;
  localparam logic [1:0] CH_STEREO = 2'd2;

  localparam logic [5:0] BITS_8  = 6'd8;
  localparam logic [5:0] BITS_16 = 6'd16;
  localparam logic [5:0] BITS_24 = 6'd24;
  localparam logic [5:0] BITS_32 = 6'd32;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_POINT  = 2'd2;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_RIFF      = 4'd1;
  localparam logic [3:0] ERR_WAVE      = 4'd2;
  localparam logic [3:0] ERR_FMT       = 4'd3;
  localparam logic [3:0] ERR_FMT_LEN   = 4'd4;
  localparam logic [3:0] ERR_NOT_PCM   = 4'd5;
  localparam logic [3:0] ERR_CHANNELS  = 4'd6;
  localparam logic [3:0] ERR_BITS      = 4'd7;
  localparam logic [3:0] ERR_RATES     = 4'd8;
  localparam logic [3:0] ERR_DATA      = 4'd9;

  // rate check: 32-bit rate times a 7-bit (bits * channels) factor
  localparam int RC_MPLIER_W = 7;
  localparam int RC_PROD_W   = 32 + RC_MPLIER_W;
  localparam logic [2:0] RC_LAST_STEP = 3'(RC_MPLIER_W - 1);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_SAMPLES = 2'd1,
    PH_HALT    = 2'd2
  } phase_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_CHECK = 1'b1
  } seq_e;

  typedef struct packed {
    logic done;
    logic match;
  } rc_status_t;

endpackage

`default_nettype wire

/* hw/rtl/wpp_rate_check.sv */
// Iterative shift-add multiplier and compare for the byte-rate check.
// Depends on wpp_pkg.
`default_nettype none

module wpp_rate_check (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [31:0]                       mcand_i,
  input  wire logic [wpp_pkg::RC_MPLIER_W-1:0]   mplier_i,
  input  wire logic [31:0]                       byte_rate_i,
  output wpp_pkg::rc_status_t                    status_o
);

  logic                            running_q, running_d;
  logic                            done_q, done_d;
  logic [2:0]                      count_q, count_d;
  logic [wpp_pkg::RC_PROD_W-1:0]   acc_q, acc_d;
  logic [wpp_pkg::RC_PROD_W-1:0]   mcand_q, mcand_d;
  logic [wpp_pkg::RC_MPLIER_W-1:0] mplier_q, mplier_d;
  logic [wpp_pkg::RC_PROD_W-1:0]   target;

  always_comb begin
    running_d = running_q;
    done_d    = done_q;
    count_d   = count_q;
    acc_d     = acc_q;
    mcand_d   = mcand_q;
    mplier_d  = mplier_q;
    if (start_i) begin
      running_d = 1'b1;
      done_d    = 1'b0;
      count_d   = '0;
      acc_d     = '0;
      mcand_d   = {{wpp_pkg::RC_MPLIER_W{1'b0}}, mcand_i};
      mplier_d  = mplier_i;
    end else if (running_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
      count_d  = count_q + 3'd1;
      if (count_q == wpp_pkg::RC_LAST_STEP) begin
        running_d = 1'b0;
        done_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      count_q   <= '0;
    end else begin
      running_q <= running_d;
      done_q    <= done_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  // 8 * byte_rate
  assign target = {{(wpp_pkg::RC_PROD_W - 35){1'b0}}, byte_rate_i, 3'b000};

  assign status_o.done  = done_q;
  assign status_o.match = (acc_q == target);

endmodule

`default_nettype wire

/* hw/rtl/wav_pcm_stream_parser.sv */
// WAV PCM stream parser: one file byte per item, header checks, then sample points.
// The input stalls after the bits-per-sample header byte while the 7-step shift-add
// multiplier in wpp_rate_check does the byte-rate check.
// At most one result per item, held in one output register; input stalls while it
// holds a result that the receiver stalls.
// Reset clears parse state and the delay register; payload registers are not reset.
// Depends on wpp_pkg and wpp_rate_check.
`default_nettype none

module wav_pcm_stream_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  file_byte_i,
  input  wire logic        start_of_file_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [3:0]       error_code_o,
  output logic             length_mismatch_o,
  output logic [1:0]       channel_count_o,
  output logic [5:0]       sample_bits_o,
  output logic [31:0]      rate_hz_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o
);

  wpp_pkg::seq_e   state_q, state_d;
  wpp_pkg::phase_e phase_q, phase_d;

  logic        delay_q;
  logic [5:0]  pos_q, pos_d;
  logic [31:0] facc_q, facc_d;
  logic [31:0] riff_q, riff_d;
  logic [31:0] rate_q, rate_d;
  logic [31:0] brate_q, brate_d;
  logic [1:0]  ch_q, ch_d;
  logic [5:0]  bits_q, bits_d;
  logic [31:0] sasm_q, sasm_d;
  logic [1:0]  bis_q, bis_d;
  logic [31:0] held_q, held_d;
  logic        slot_q, slot_d;
  logic [31:0] prev_q, prev_d;
  logic        havep_q, havep_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_kind_q;
  logic [3:0]  out_err_q;
  logic        out_mism_q;
  logic [1:0]  out_ch_q;
  logic [5:0]  out_bits_q;
  logic [31:0] out_rate_q;
  logic [31:0] out_x_q;
  logic [31:0] out_y_q;

  logic        out_free, accept, check_exit;
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [3:0]  res_err;
  logic        res_mism;
  logic [31:0] res_x, res_y;

  logic                            rc_start;
  logic [wpp_pkg::RC_MPLIER_W-1:0] rc_mplier;
  wpp_pkg::rc_status_t             rc_status;

  // sequencer outputs
  always_comb begin
    out_free   = !out_valid_q || !out_stall_i;
    in_stall_o = (state_q == wpp_pkg::ST_CHECK) || !out_free;
    check_exit = (state_q == wpp_pkg::ST_CHECK) && rc_status.done && out_free;
  end

  assign accept = in_valid_i && !in_stall_o;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wpp_pkg::ST_IDLE:  if (rc_start) state_d = wpp_pkg::ST_CHECK;
      wpp_pkg::ST_CHECK: if (check_exit) state_d = wpp_pkg::ST_IDLE;
      default:           state_d = wpp_pkg::ST_IDLE;
    endcase
  end

  // datapath for one accepted item, and the rate-check result at check exit
  always_comb begin
    logic [5:0]  p;
    logic [1:0]  off;
    logic [31:0] a;
    logic [2:0]  nbytes;
    logic [1:0]  k;
    logic [31:0] v;

    phase_d = phase_q;
    pos_d   = pos_q;
    facc_d  = facc_q;
    riff_d  = riff_q;
    rate_d  = rate_q;
    brate_d = brate_q;
    ch_d    = ch_q;
    bits_d  = bits_q;
    sasm_d  = sasm_q;
    bis_d   = bis_q;
    held_d  = held_q;
    slot_d  = slot_q;
    prev_d  = prev_q;
    havep_d = havep_q;

    res_valid = 1'b0;
    res_kind  = wpp_pkg::KIND_POINT;
    res_err   = wpp_pkg::ERR_NONE;
    res_mism  = 1'b0;
    res_x     = '0;
    res_y     = '0;
    rc_start  = 1'b0;
    rc_mplier = '0;

    p      = '0;
    off    = '0;
    a      = '0;
    nbytes = '0;
    k      = '0;
    v      = '0;

    if (accept) begin
      if (start_of_file_i) begin
        phase_d = wpp_pkg::PH_HEADER;
        pos_d   = '0;
        facc_d  = '0;
        riff_d  = '0;
        rate_d  = '0;
        brate_d = '0;
        ch_d    = '0;
        bits_d  = '0;
        sasm_d  = '0;
        bis_d   = '0;
        held_d  = '0;
        slot_d  = 1'b0;
        prev_d  = '0;
        havep_d = 1'b0;
      end

      unique case (phase_d)
        wpp_pkg::PH_HEADER: begin
          p = pos_d;
          if ((p >= wpp_pkg::SHORT_A_LO && p < wpp_pkg::SHORT_A_HI) ||
              (p >= wpp_pkg::SHORT_B_LO && p < wpp_pkg::SHORT_B_HI)) begin
            off = {1'b0, p[0]};
          end else begin
            off = p[1:0];
          end
          if (off == 2'd0) begin
            a = {24'b0, file_byte_i};
          end else begin
            a = facc_d | ({24'b0, file_byte_i} << {off, 3'b000});
          end
          facc_d = a;
          pos_d  = p + 6'd1;
          res_kind = wpp_pkg::KIND_REJECT;

          unique case (p)
            wpp_pkg::POS_RIFF: if (a != wpp_pkg::TAG_RIFF) begin
              res_valid = 1'b1;
              res_err   = wpp_pkg::ERR_RIFF;
            end
            wpp_pkg::POS_RIFF_SIZE: riff_d = a;
            wpp_pkg::POS_WAVE: if (a != wpp_pkg::TAG_WAVE) begin
              res_valid = 1'b1;
              res_err   = wpp_pkg::ERR_WAVE;
            end
            wpp_pkg::POS_FMT: if (a != wpp_pkg::TAG_FMT) begin
              res_valid = 1'b1;
              res_err   = wpp_pkg::ERR_FMT;
            end
            wpp_pkg::POS_FMT_LEN: if (a != wpp_pkg::FMT_LEN) begin
              res_valid = 1'b1;
              res_err   = wpp_pkg::ERR_FMT_LEN;
            end
            wpp_pkg::POS_FMT_TYPE: if (a != wpp_pkg::FMT_PCM) begin
              res_valid = 1'b1;
              res_err   = wpp_pkg::ERR_NOT_PCM;
            end
            wpp_pkg::POS_CHANNELS: begin
              if (a != {30'b0, wpp_pkg::CH_MONO} && a != {30'b0, wpp_pkg::CH_STEREO}) begin
                res_valid = 1'b1;
                res_err   = wpp_pkg::ERR_CHANNELS;
              end else begin
                ch_d = a[1:0];
              end
            end
            wpp_pkg::POS_RATE:      rate_d  = a;
            wpp_pkg::POS_BYTE_RATE: brate_d = a;
            wpp_pkg::POS_BITS: begin
              if (a != {26'b0, wpp_pkg::BITS_8}  && a != {26'b0, wpp_pkg::BITS_16} &&
                  a != {26'b0, wpp_pkg::BITS_24} && a != {26'b0, wpp_pkg::BITS_32}) begin
                res_valid = 1'b1;
                res_err   = wpp_pkg::ERR_BITS;
              end else begin
                // rate consistency is settled by the rate-check multiplier
                bits_d    = a[5:0];
                rc_start  = 1'b1;
                rc_mplier = {1'b0, a[5:0]} << ((ch_d == wpp_pkg::CH_STEREO) ? 1 : 0);
              end
            end
            wpp_pkg::POS_DATA: if (a != wpp_pkg::TAG_DATA) begin
              res_valid = 1'b1;
              res_err   = wpp_pkg::ERR_DATA;
            end
            wpp_pkg::POS_LAST: begin
              phase_d   = wpp_pkg::PH_SAMPLES;
              bis_d     = '0;
              sasm_d    = '0;
              slot_d    = 1'b0;
              havep_d   = 1'b0;
              res_valid = 1'b1;
              res_kind  = wpp_pkg::KIND_ACCEPT;
              res_mism  = (({1'b0, a} + wpp_pkg::SIZE_OFFSET) != {1'b0, riff_d});
            end
            default: ;
          endcase
          if (res_valid && res_kind == wpp_pkg::KIND_REJECT) begin
            phase_d = wpp_pkg::PH_HALT;
          end
        end

        wpp_pkg::PH_SAMPLES: begin
          nbytes = bits_d[5:3];
          if (nbytes < 3'd1 || nbytes > 3'd4) begin
            nbytes = 3'd1;
          end
          k = bis_d;
          if (k == 2'd0) begin
            sasm_d = {24'b0, file_byte_i};
          end else begin
            sasm_d = sasm_d | ({24'b0, file_byte_i} << {k, 3'b000});
          end
          if ({1'b0, k} + 3'd1 < nbytes) begin
            bis_d = k + 2'd1;
          end else begin
            bis_d = '0;
            unique case (nbytes)
              3'd1:    v = {{24{sasm_d[7]}}, sasm_d[7:0]};
              3'd2:    v = {{16{sasm_d[15]}}, sasm_d[15:0]};
              3'd3:    v = {{8{sasm_d[23]}}, sasm_d[23:0]};
              default: v = sasm_d;
            endcase
            if (!slot_d) begin
              held_d = v;
              slot_d = 1'b1;
            end else begin
              slot_d   = 1'b0;
              res_kind = wpp_pkg::KIND_POINT;
              res_y    = v;
              if (ch_d != wpp_pkg::CH_STEREO) begin
                res_valid = 1'b1;
                res_x     = held_d;
              end else begin
                prev_d  = held_d;
                havep_d = 1'b1;
                if (delay_q) begin
                  // first stereo tick after the header has no earlier left value
                  res_valid = havep_q && !start_of_file_i;
                  res_x     = prev_q;
                end else begin
                  res_valid = 1'b1;
                  res_x     = held_d;
                end
              end
            end
          end
        end

        default: ;
      endcase
    end else if (check_exit && !rc_status.match) begin
      phase_d   = wpp_pkg::PH_HALT;
      res_valid = 1'b1;
      res_kind  = wpp_pkg::KIND_REJECT;
      res_err   = wpp_pkg::ERR_RATES;
    end
  end

  assign out_valid_d = res_valid ? 1'b1 : (out_free ? 1'b0 : out_valid_q);

  wpp_rate_check u_rate_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (rc_start),
    .mcand_i     (rate_d),
    .mplier_i    (rc_mplier),
    .byte_rate_i (brate_q),
    .status_o    (rc_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wpp_pkg::ST_IDLE;
      phase_q     <= wpp_pkg::PH_HEADER;
      delay_q     <= 1'b0;
      pos_q       <= '0;
      facc_q      <= '0;
      riff_q      <= '0;
      rate_q      <= '0;
      brate_q     <= '0;
      ch_q        <= '0;
      bits_q      <= '0;
      sasm_q      <= '0;
      bis_q       <= '0;
      held_q      <= '0;
      slot_q      <= 1'b0;
      prev_q      <= '0;
      havep_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      if (cfg_we_i) begin
        delay_q <= cfg_wdata_i;
      end
      pos_q       <= pos_d;
      facc_q      <= facc_d;
      riff_q      <= riff_d;
      rate_q      <= rate_d;
      brate_q     <= brate_d;
      ch_q        <= ch_d;
      bits_q      <= bits_d;
      sasm_q      <= sasm_d;
      bis_q       <= bis_d;
      held_q      <= held_d;
      slot_q      <= slot_d;
      prev_q      <= prev_d;
      havep_q     <= havep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_kind_q <= res_kind;
      out_err_q  <= res_err;
      out_mism_q <= res_mism;
      out_ch_q   <= ch_d;
      out_bits_q <= bits_d;
      out_rate_q <= rate_d;
      out_x_q    <= res_x;
      out_y_q    <= res_y;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = out_kind_q;
  assign error_code_o      = out_err_q;
  assign length_mismatch_o = out_mism_q;
  assign channel_count_o   = out_ch_q;
  assign sample_bits_o     = out_bits_q;
  assign rate_hz_o         = out_rate_q;
  assign point_x_o         = out_x_q;
  assign point_y_o         = out_y_q;

endmodule

`default_nettype wire
